### hdl/cla_pkg.sv
// Shared constants and types for the console line assembler.
// Depends on nothing; imported by console_line_assembler, cla_decode and tb_top.
`default_nettype none

package cla_pkg;

    // Line capacity in characters (1 to 63).
    localparam int LINE_CHARS = 63;
    localparam int FILL_W     = $clog2(LINE_CHARS + 1);
    localparam int ADDR_W     = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

    // Control byte codes.
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // Result kinds.
    localparam logic KIND_CHAR     = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    // Byte class; a byte with no flag set is an illegal byte.
    typedef struct packed {
        logic term;
        logic bksp;
        logic append;
    } byte_class_t;

endpackage

`default_nettype wire

### hdl/console_line_assembler.sv
// Top level of the console line assembler: control sequencer around the line store.
// Depends on cla_pkg, cla_decode and cla_ram.
`default_nettype none

// Usage:
// The slave stream carries one received byte per beat in s_axis_tdata, with the
// receiver's error flag in s_axis_tuser. Tab and printable characters are
// stored in a line RAM, backspace drops the last one, and CR or LF ends the line.
// Ending a non-empty line reads the stored characters back out of the RAM and
// sends them on the master stream, one beat each, tlast on the final one.
// An illegal byte, a receive error or an append to a full line clears the line
// and discards bytes until the next terminator, which sends a single overflow
// beat (tuser set, tdata zero, tlast set).
// Ordinary bytes are taken one per cycle while the block is idle and its output
// register is free. A terminator for a non-empty line holds the input off while
// the line is read out: the READ state issues the first RAM read, then the DATA
// state sends one character per cycle while the receiver is ready, issuing the
// next read with each; both the RAM read and the output beat are registered.
// Writes to the RAM only happen while idle, and reads only during readout, so
// a read never overlaps a write to the same entry.
// When the receiver stalls, the output register holds its beat and readout
// pauses; the input is taken again once the block is idle and the output
// register is empty or being drained. Reset empties the line, leaves discard
// mode and drops any pending output beat; the RAM contents are not cleared.

module console_line_assembler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // rx_byte[7:0]
    input  wire logic [0:0] s_axis_tuser,   // rx_error[0]
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // char_out[7:0]
    output logic [0:0]      m_axis_tuser,   // kind[0]
    output logic            m_axis_tlast
);
    import cla_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              discard_reg, discard_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;

    logic              ovalid_reg, ovalid_next;
    logic              okind_reg, okind_next;
    logic [7:0]        ochar_reg, ochar_next;
    logic              olast_reg, olast_next;

    byte_class_t       cls;
    logic              in_fire;
    logic              out_free;
    logic              last_hit;

    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    cla_decode u_decode (
        .rx_byte (s_axis_tdata),
        .cls     (cls)
    );

    cla_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CHARS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free      = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign last_hit      = (fill_reg == (FILL_W'(ptr_reg) + FILL_W'(1)));

    assign m_axis_tvalid   = ovalid_reg;
    assign m_axis_tdata    = ochar_reg;
    assign m_axis_tuser[0] = okind_reg;
    assign m_axis_tlast    = olast_reg;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        discard_next = discard_reg;
        ptr_next     = ptr_reg;
        ovalid_next  = ovalid_reg && !m_axis_tready;
        okind_next   = okind_reg;
        ochar_next   = ochar_reg;
        olast_next   = olast_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser[0])
                    begin
                        discard_next = 1'b1;
                        fill_next    = '0;
                    end
                    else if (cls.term)
                    begin
                        if (discard_reg)
                        begin
                            // End of a discarded line: one overflow beat.
                            discard_next = 1'b0;
                            fill_next    = '0;
                            ovalid_next  = 1'b1;
                            okind_next   = KIND_OVERFLOW;
                            ochar_next   = '0;
                            olast_next   = 1'b1;
                        end
                        else if (fill_reg != '0)
                        begin
                            ptr_next   = '0;
                            state_next = ST_READ;
                        end
                    end
                    else if (!discard_reg)
                    begin
                        if (cls.bksp)
                        begin
                            if (fill_reg != '0)
                            begin
                                fill_next = fill_reg - FILL_W'(1);
                            end
                        end
                        else if (cls.append &&
                                 (fill_reg != FILL_W'(LINE_CHARS)))
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                        end
                        else
                        begin
                            // Illegal byte or full line.
                            discard_next = 1'b1;
                            fill_next    = '0;
                        end
                    end
                end
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_DATA;
            end

            ST_DATA:
            begin
                // rd_data holds the character at ptr_reg until the next read.
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_CHAR;
                    ochar_next  = rd_data;
                    olast_next  = last_hit;
                    if (last_hit)
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg + ADDR_W'(1);
                        ptr_next = ptr_reg + ADDR_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            discard_reg <= 1'b0;
            ptr_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            discard_reg <= discard_next;
            ptr_reg     <= ptr_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        okind_reg <= okind_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

`ifndef SYNTH
    // The line never holds more characters than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LINE_CHARS))
        else $error("line fill count exceeds capacity");

    // Readout only runs for a line that was not being discarded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !discard_reg)
        else $error("readout while in discard mode");

    // An overflow beat is always a run of one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && okind_reg) |-> olast_reg)
        else $error("overflow beat without last");

    // The final character of a readout returns the block to idle with an empty line.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DATA) && out_free && last_hit) |=>
        ((state_reg == ST_IDLE) && (fill_reg == '0) && ovalid_reg && olast_reg))
        else $error("readout did not finish cleanly");
`endif

endmodule

`default_nettype wire

### hdl/cla_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; used for the line store of the console line assembler.
`default_nettype none

module cla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // The read register holds its value until the next read.
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/cla_decode.sv
// Classifies a received byte as terminator, backspace, appendable or illegal.
// Depends on cla_pkg.
`default_nettype none

module cla_decode (
    input  wire logic [7:0]          rx_byte,
    output cla_pkg::byte_class_t     cls
);
    import cla_pkg::*;

    always_comb
    begin
        cls.term   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
        cls.bksp   = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
        cls.append = (rx_byte == CH_TAB) ||
                     ((rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE));
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the console line assembler stream block.
// Depends on cla_pkg and console_line_assembler from the hdl folder; reads no files.
// Drives received bytes in, predicts the line output and checks every output beat.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cla_pkg::*;

    // Generous bound: every beat of a 63 character line waiting out the longest
    // random stall, plus the long hold-off, still fits many times over.
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int HOLD_CYCLES    = 200;

    // One output beat as the block presents it.
    typedef struct packed {
        logic       kind;
        logic [7:0] char_out;
        logic       last;
    } line_beat_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;    // rx_byte[7:0]
    logic [0:0] s_axis_tuser  = 1'b0;    // rx_error[0]
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // char_out[7:0]
    logic [0:0] m_axis_tuser;            // kind[0]
    logic       m_axis_tlast;

    // Shadow copy of the line being built, kept in step with accepted beats.
    logic [7:0] held_chars [LINE_CHARS];
    int         held_count    = 0;
    bit         discarding    = 1'b0;
    line_beat_t expected_beats [$];

    int error_count     = 0;
    int counted_items   = 0;    // accepted bytes not swallowed by discard mode
    bit idle_on         = 1'b0; // random gaps on both sides while set
    int hold_out_cycles = 0;    // request for one long receiver hold-off
    int cycle_count     = 0;

    console_line_assembler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // Line editor prediction for one accepted byte. Pushes the beats the byte
    // releases and returns 1 unless the byte was swallowed by discard mode.
    function automatic bit model_line_byte(input logic [7:0] rx_byte, input logic rx_error);
        line_beat_t beat;
        bit         counted;
        int         k;
        counted = !discarding || (!rx_error && (rx_byte == CH_CR || rx_byte == CH_LF));
        if (rx_error) begin
            discarding = 1'b1;
            held_count = 0;
        end
        else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
            if (discarding) begin
                // The terminator closes a discarded line with one overflow beat.
                discarding    = 1'b0;
                held_count    = 0;
                beat.kind     = KIND_OVERFLOW;
                beat.char_out = 8'd0;
                beat.last     = 1'b1;
                expected_beats.push_back(beat);
            end
            else begin
                // An empty line produces nothing at all.
                for (k = 0; k < held_count; k++) begin
                    beat.kind     = KIND_CHAR;
                    beat.char_out = held_chars[k];
                    beat.last     = (k == held_count - 1);
                    expected_beats.push_back(beat);
                end
                held_count = 0;
            end
        end
        else if (discarding) begin
            // Everything but a terminator is dropped, backspace included.
        end
        else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
            if (held_count > 0)
                held_count--;
        end
        else if (rx_byte == CH_TAB || (rx_byte >= CH_SPACE && rx_byte <= CH_TILDE)) begin
            if (held_count < LINE_CHARS) begin
                held_chars[held_count] = rx_byte;
                held_count++;
            end
            else begin
                // Appending to a full line throws the whole line away.
                discarding = 1'b1;
                held_count = 0;
            end
        end
        else begin
            // Any other control code is treated as line noise.
            discarding = 1'b1;
            held_count = 0;
        end
        return counted;
    endfunction

    function automatic logic [7:0] random_line_char();
        if ($urandom_range(0, 11) == 0)
            return CH_TAB;
        return 8'($urandom_range(CH_SPACE, CH_TILDE));
    endfunction

    // Offers one byte on the input stream and waits until the block takes it.
    // The handshake is sampled at the clock edge, before the block updates.
    task automatic send_beat(input logic [7:0] rx_byte, input logic rx_error);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_byte;
        s_axis_tuser  <= rx_error;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (model_line_byte(rx_byte, rx_error))
            counted_items++;
    endtask

    task automatic send_text(input string text);
        int k;
        for (k = 0; k < text.len(); k++)
            send_beat(text[k], 1'b0);
    endtask

    task automatic send_random_chars(input int count);
        int k;
        for (k = 0; k < count; k++)
            send_beat(random_line_char(), 1'b0);
    endtask

    // Short hand-picked sequences: field extremes and each line editing corner.
    task automatic test_directed_cases();
        send_text("AB");
        send_beat(CH_CR, 1'b0);
        // Empty lines ended by either terminator give no output.
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        // Backspace and delete on an empty line are ignored.
        send_beat(CH_BS, 1'b0);
        send_beat(CH_DEL, 1'b0);
        // Edges of the printable range plus tab, then erase the last two.
        send_beat(CH_TAB, 1'b0);
        send_beat(CH_SPACE, 1'b0);
        send_beat(CH_TILDE, 1'b0);
        send_text("x");
        send_beat(CH_DEL, 1'b0);
        send_beat(CH_BS, 1'b0);
        send_beat(CH_LF, 1'b0);
        // Illegal control code, then bytes and an error while discarding.
        send_beat(8'h00, 1'b0);
        send_text("a");
        send_beat(CH_BS, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(CH_LF, 1'b0);
        // Receive error in the middle of a line.
        send_text("q");
        send_beat(8'h00, 1'b1);
        send_beat(CH_CR, 1'b0);
        // A top-half byte is illegal too; the code just below space then falls in discard mode.
        send_beat(8'h80, 1'b0);
        send_beat(8'h1F, 1'b0);
        send_beat(CH_CR, 1'b0);
    endtask

    // A line filled to capacity, trimmed by one and filled again, then a line
    // one character past the capacity.
    task automatic test_full_line();
        send_random_chars(LINE_CHARS);
        send_beat(CH_BS, 1'b0);
        send_random_chars(1);
        send_beat(CH_CR, 1'b0);
        send_random_chars(LINE_CHARS + 1);
        send_beat(CH_LF, 1'b0);
    endtask

    // Mostly well-formed lines with random content and length, with a few
    // erasures, noise bytes and receive errors mixed in.
    task automatic test_random_lines(input int item_count);
        int goal;
        int len;
        int pick;
        int k;
        goal = counted_items + item_count;
        while (counted_items < goal) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = LINE_CHARS + $urandom_range(1, 2);
            else if (pick < 3)
                len = $urandom_range(30, LINE_CHARS);
            else
                len = $urandom_range(0, 12);
            for (k = 0; k < len; k++) begin
                send_beat(random_line_char(), 1'b0);
                if ($urandom_range(0, 9) == 0)
                    send_beat($urandom_range(0, 1) ? CH_BS : CH_DEL, 1'b0);
            end
            if ($urandom_range(0, 7) == 0)
                send_beat(8'($urandom), 1'($urandom_range(0, 1)));
            send_beat($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
        end
    endtask

    // The receiver stops for a long stretch while two lines are offered, so
    // the single output register fills and the block holds its input off.
    task automatic test_output_hold();
        int n;
        hold_out_cycles = HOLD_CYCLES;
        for (n = 0; n < 2; n++) begin
            send_random_chars(20);
            send_beat(CH_CR, 1'b0);
        end
    endtask

    // Receiver side: random stall bursts, one long hold-off on request,
    // otherwise always ready.
    initial begin
        forever begin
            if (hold_out_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_out_cycles) @(posedge clk);
                hold_out_cycles = 0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compares each output beat with the oldest prediction.
    always @(posedge clk) begin
        line_beat_t got;
        line_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind     = m_axis_tuser[0];
            got.char_out = m_axis_tdata;
            got.last     = m_axis_tlast;
            if (expected_beats.size() == 0) begin
                $display("%0t: beat with nothing expected: kind=%0d char=%02h last=%0d",
                         $time, got.kind, got.char_out, got.last);
                error_count++;
            end
            else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    $display({"%0t: expected kind=%0d char=%02h last=%0d, ",
                              "got kind=%0d char=%02h last=%0d"},
                             $time, want.kind, want.char_out, want.last,
                             got.kind, got.char_out, got.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;
        test_directed_cases();
        test_full_line();
        test_random_lines(40);
        test_output_hold();
        // Closing stretch at full rate on both sides.
        idle_on = 1'b0;
        test_random_lines(20);
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
